// File: hw/rtl/chm_pkg.sv
// ----------------------------------------------------------------------------
// chm_pkg
// Shared constants, codes and helpers for the chained overflow hash map.
// ----------------------------------------------------------------------------
package chm_pkg;

   localparam int TABLE_SLOTS = 256;
   localparam int HOME_AW     = $clog2(TABLE_SLOTS);
   localparam int SLOT_AW     = HOME_AW + 1;
   localparam int TOTAL_SLOTS = 2 * TABLE_SLOTS;
   localparam int KEY_BITS    = 64;
   localparam int VALUE_BITS  = 64;
   localparam int COUNT_W     = 9;
   localparam int KV_W        = KEY_BITS + VALUE_BITS;

   localparam logic [63:0] GOLDEN_MULT = 64'd11400714785074694791;
   localparam logic [63:0] HASH_PRIME  = 64'hFFFF_FFFF_FFFF_FFC5;

   // link codes
   localparam logic [SLOT_AW-1:0] LINK_EMPTY = '0;
   localparam logic [SLOT_AW-1:0] LINK_END   = SLOT_AW'(1);

   typedef enum logic [1:0] {
      OP_LOOKUP = 2'd0,
      OP_INSERT = 2'd1,
      OP_DELETE = 2'd2
   } opcode_type;

   localparam logic [1:0] STAT_MISS     = 2'd0;
   localparam logic [1:0] STAT_HIT      = 2'd1;
   localparam logic [1:0] STAT_INSERTED = 2'd2;
   localparam logic [1:0] STAT_FULL     = 2'd3;

   // overflow slots are the upper half of the slot space
   function automatic logic slot_is_overflow(input logic [SLOT_AW-1:0] link);
      return link[SLOT_AW-1];
   endfunction

endpackage

// File: hw/rtl/chm_ram.sv
// ----------------------------------------------------------------------------
// chm_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module chm_ram #(
   parameter int DATA_W = 8,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/chm_hash.sv
// ----------------------------------------------------------------------------
// chm_hash
// Home slot of a key: golden-ratio multiply mod 2^64 from three 32x32
// partial products, reduction mod 2^64-59, then the low index bits.
// ----------------------------------------------------------------------------
module chm_hash (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [chm_pkg::KEY_BITS-1:0]    key,
   output logic                            done,
   output logic [chm_pkg::HOME_AW-1:0]     home
);
   import chm_pkg::*;

   logic [2:0]          step_ff, step_in;
   logic [63:0]         key_ff, key_in;
   logic [63:0]         m0_ff, m0_in;
   logic [31:0]         m1_ff, m1_in;
   logic [31:0]         m2_ff, m2_in;
   logic [63:0]         p_ff, p_in;
   logic [HOME_AW-1:0]  home_ff, home_in;
   logic                done_ff, done_in;
   logic [63:0]         p_red;

   always_comb begin
      step_in = step_ff;
      key_in  = key_ff;
      m0_in   = m0_ff;
      m1_in   = m1_ff;
      m2_in   = m2_ff;
      p_in    = p_ff;
      home_in = home_ff;
      done_in = 1'b0;
      p_red   = (p_ff >= HASH_PRIME) ? p_ff - HASH_PRIME : p_ff;
      case (step_ff)
         3'd0: begin
            if (start) begin
               key_in  = 64'(key);
               step_in = 3'd1;
            end
         end
         3'd1: begin
            m0_in   = key_ff[31:0] * GOLDEN_MULT[31:0];
            step_in = 3'd2;
         end
         3'd2: begin
            m1_in   = key_ff[31:0] * GOLDEN_MULT[63:32];
            step_in = 3'd3;
         end
         3'd3: begin
            m2_in   = key_ff[63:32] * GOLDEN_MULT[31:0];
            step_in = 3'd4;
         end
         3'd4: begin
            p_in    = m0_ff + {m1_ff + m2_ff, 32'h0};
            step_in = 3'd5;
         end
         default: begin
            home_in = p_red[HOME_AW-1:0];
            done_in = 1'b1;
            step_in = 3'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= 3'd0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= done_in;
      end
      key_ff  <= key_in;
      m0_ff   <= m0_in;
      m1_ff   <= m1_in;
      m2_ff   <= m2_in;
      p_ff    <= p_in;
      home_ff <= home_in;
   end

   assign done = done_ff;
   assign home = home_ff;

endmodule

// File: hw/rtl/chained_overflow_hash_map.sv
// ----------------------------------------------------------------------------
// chained_overflow_hash_map
// Key/value map: home area plus overflow area, chains walked in link RAM.
// ----------------------------------------------------------------------------
// Sequence: the key is hashed, one chain slot is read per step of the walk,
//   then the result is registered; a delete may pull the successor forward and
//   then clears a slot, an append writes the tail link and probes for a free slot (up to 256 probes).
// Throughput: one transaction at a time; req_stall is high outside ST_IDLE.
// Reset: a pass over all 512 slots clears the link RAM; req_stall is high meanwhile.
module chained_overflow_hash_map (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_opcode,
   input  logic [chm_pkg::KEY_BITS-1:0]      req_key,
   input  logic [chm_pkg::VALUE_BITS-1:0]    req_value_in,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_status,
   output logic [chm_pkg::VALUE_BITS-1:0]    rsp_value_out,
   output logic [chm_pkg::COUNT_W-1:0]       rsp_entry_count
);
   import chm_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_HASH, ST_WALK, ST_INS_TAIL,
      ST_SCAN_RD, ST_SCAN_CK, ST_DEL_MOVE, ST_DEL_CLR, ST_DONE
   } state_type;

   state_type              state_ff, state_in;
   logic [1:0]             op_ff, op_in;
   logic [KEY_BITS-1:0]    key_ff, key_in;
   logic [VALUE_BITS-1:0]  val_ff, val_in;
   logic [SLOT_AW-1:0]     cur_ff, cur_in;
   logic [SLOT_AW-1:0]     prev_ff, prev_in;
   logic                   has_prev_ff, has_prev_in;
   logic                   first_ff, first_in;
   logic [SLOT_AW-1:0]     aux_ff, aux_in;
   logic [SLOT_AW-1:0]     fp_ff, fp_in;
   logic [COUNT_W-1:0]     cnt_ff, cnt_in;
   logic [HOME_AW:0]       probe_ff, probe_in;
   logic [1:0]             status_ff, status_in;
   logic [VALUE_BITS-1:0]  vout_ff, vout_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             rsp_status_ff, rsp_status_in;
   logic [VALUE_BITS-1:0]  rsp_value_out_ff, rsp_value_out_in;
   logic [COUNT_W-1:0]     rsp_entry_count_ff, rsp_entry_count_in;

   logic                   link_we, kv_we;
   logic [SLOT_AW-1:0]     link_wa, kv_wa, rd_addr;
   logic [SLOT_AW-1:0]     link_wd, link_rd;
   logic [KV_W-1:0]        kv_wd, kv_rd;
   logic [KEY_BITS-1:0]    rd_key;
   logic [VALUE_BITS-1:0]  rd_val;
   logic                   hash_start, hash_done;
   logic [HOME_AW-1:0]     hash_home;
   logic                   home_empty, key_hit;

   chm_ram #(.DATA_W(SLOT_AW), .ADDR_W(SLOT_AW)) u_link_ram (
      .clock  (clock),
      .wr_en  (link_we),
      .wr_addr(link_wa),
      .wr_data(link_wd),
      .rd_addr(rd_addr),
      .rd_data(link_rd)
   );

   chm_ram #(.DATA_W(KV_W), .ADDR_W(SLOT_AW)) u_kv_ram (
      .clock  (clock),
      .wr_en  (kv_we),
      .wr_addr(kv_wa),
      .wr_data(kv_wd),
      .rd_addr(rd_addr),
      .rd_data(kv_rd)
   );

   chm_hash u_hash (
      .clock(clock),
      .reset(reset),
      .start(hash_start),
      .key  (key_in),
      .done (hash_done),
      .home (hash_home)
   );

   assign rd_key     = kv_rd[VALUE_BITS +: KEY_BITS];
   assign rd_val     = kv_rd[VALUE_BITS-1:0];
   assign home_empty = first_ff && (link_rd == LINK_EMPTY);
   assign key_hit    = !home_empty && (rd_key == key_ff);

   always_comb begin
      state_in           = state_ff;
      op_in              = op_ff;
      key_in             = key_ff;
      val_in             = val_ff;
      cur_in             = cur_ff;
      prev_in            = prev_ff;
      has_prev_in        = has_prev_ff;
      first_in           = first_ff;
      aux_in             = aux_ff;
      fp_in              = fp_ff;
      cnt_in             = cnt_ff;
      probe_in           = probe_ff;
      status_in          = status_ff;
      vout_in            = vout_ff;
      rsp_status_in      = rsp_status_ff;
      rsp_value_out_in   = rsp_value_out_ff;
      rsp_entry_count_in = rsp_entry_count_ff;
      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      link_we            = 1'b0;
      link_wa            = cur_ff;
      link_wd            = LINK_EMPTY;
      kv_we              = 1'b0;
      kv_wa              = cur_ff;
      kv_wd              = {key_ff, val_ff};
      rd_addr            = cur_ff;
      hash_start         = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            link_we = 1'b1;
            link_wa = aux_ff;
            aux_in  = aux_ff + 1'b1;
            if (aux_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               op_in      = req_opcode;
               key_in     = req_key;
               val_in     = req_value_in;
               hash_start = 1'b1;
               state_in   = ST_HASH;
            end
         end
         ST_HASH: begin
            if (hash_done) begin
               rd_addr     = {1'b0, hash_home};
               cur_in      = {1'b0, hash_home};
               first_in    = 1'b1;
               has_prev_in = 1'b0;
               state_in    = ST_WALK;
            end
         end
         ST_WALK: begin
            status_in = STAT_MISS;
            vout_in   = '0;
            state_in  = ST_DONE;
            if (!key_hit && !home_empty && slot_is_overflow(link_rd)) begin
               // follow the chain
               prev_in     = cur_ff;
               has_prev_in = 1'b1;
               first_in    = 1'b0;
               cur_in      = link_rd;
               rd_addr     = link_rd;
               state_in    = ST_WALK;
            end else begin
               case (op_ff)
                  OP_LOOKUP: begin
                     if (key_hit) begin
                        status_in = STAT_HIT;
                        vout_in   = rd_val;
                     end
                  end
                  OP_INSERT: begin
                     if (key_hit) begin
                        kv_we     = 1'b1;
                        status_in = STAT_HIT;
                     end else if (cnt_ff >= COUNT_W'(TABLE_SLOTS)) begin
                        status_in = STAT_FULL;
                     end else if (link_rd == LINK_EMPTY) begin
                        link_we   = 1'b1;
                        link_wd   = LINK_END;
                        kv_we     = 1'b1;
                        cnt_in    = cnt_ff + 1'b1;
                        status_in = STAT_INSERTED;
                     end else begin
                        // append at the free overflow slot
                        link_we   = 1'b1;
                        link_wd   = fp_ff;
                        kv_we     = 1'b1;
                        kv_wa     = fp_ff;
                        aux_in    = fp_ff;
                        cnt_in    = cnt_ff + 1'b1;
                        status_in = STAT_INSERTED;
                        state_in  = ST_INS_TAIL;
                     end
                  end
                  OP_DELETE: begin
                     if (key_hit) begin
                        status_in = STAT_HIT;
                        vout_in   = rd_val;
                        if (cnt_ff != '0) begin
                           cnt_in = cnt_ff - 1'b1;
                        end
                        if (slot_is_overflow(link_rd)) begin
                           // pull the successor forward
                           rd_addr  = link_rd;
                           aux_in   = link_rd;
                           state_in = ST_DEL_MOVE;
                        end else begin
                           if (has_prev_ff) begin
                              link_we = 1'b1;
                              link_wa = prev_ff;
                              link_wd = LINK_END;
                           end
                           aux_in   = cur_ff;
                           state_in = ST_DEL_CLR;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_INS_TAIL: begin
            link_we  = 1'b1;
            link_wa  = aux_ff;
            link_wd  = LINK_END;
            probe_in = '0;
            state_in = ST_SCAN_RD;
         end
         ST_SCAN_RD: begin
            rd_addr  = {1'b1, fp_ff[HOME_AW-1:0] + 1'b1};
            fp_in    = {1'b1, fp_ff[HOME_AW-1:0] + 1'b1};
            probe_in = probe_ff + 1'b1;
            state_in = ST_SCAN_CK;
         end
         ST_SCAN_CK: begin
            if (link_rd == LINK_EMPTY || probe_ff == (HOME_AW+1)'(TABLE_SLOTS)) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_DEL_MOVE: begin
            link_we  = 1'b1;
            link_wd  = link_rd;
            kv_we    = 1'b1;
            kv_wd    = kv_rd;
            state_in = ST_DEL_CLR;
         end
         ST_DEL_CLR: begin
            link_we  = 1'b1;
            link_wa  = aux_ff;
            link_wd  = LINK_EMPTY;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in       = 1'b1;
               rsp_status_in      = status_ff;
               rsp_value_out_in   = vout_ff;
               rsp_entry_count_in = cnt_ff;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         aux_ff       <= '0;
         fp_ff        <= SLOT_AW'(TABLE_SLOTS);
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         aux_ff       <= aux_in;
         fp_ff        <= fp_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff              <= op_in;
      key_ff             <= key_in;
      val_ff             <= val_in;
      cur_ff             <= cur_in;
      prev_ff            <= prev_in;
      has_prev_ff        <= has_prev_in;
      first_ff           <= first_in;
      probe_ff           <= probe_in;
      status_ff          <= status_in;
      vout_ff            <= vout_in;
      rsp_status_ff      <= rsp_status_in;
      rsp_value_out_ff   <= rsp_value_out_in;
      rsp_entry_count_ff <= rsp_entry_count_in;
   end

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_value_out   = rsp_value_out_ff;
   assign rsp_entry_count = rsp_entry_count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= COUNT_W'(TABLE_SLOTS))
      else $error("entry count above table size");

   a_free_in_overflow: assert property (@(posedge clock) disable iff (reset)
      slot_is_overflow(fp_ff))
      else $error("free pointer outside overflow area");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside completion");

   a_walk_link_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK && link_we && op_ff == OP_INSERT) |-> !key_hit)
      else $error("link rewritten on an update");

endmodule
